/* hw/rtl/swf_pkg.sv */
// swf_pkg: shared types and constants of the sync word finder.
// Used by swf_core, swf_queue and sync_word_finder; depends on nothing.
package swf_pkg;

   // Longest buffer kept; bytes past this count are dropped.
   localparam int MAX_LEN     = 65536;
   localparam int BSEEN_W     = $clog2(MAX_LEN + 1);

   // One word in can cause at most this many result words.
   localparam int RESULTS_MAX = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RCNT_W      = $clog2(RESULTS_MAX + 1);

   localparam logic [15:0] STD_SYNC       = 16'h4489;
   localparam logic [6:0]  FULL_CONF      = 7'd100;
   localparam logic [15:0] SYNC_RESET     = STD_SYNC;
   localparam logic [10:0] MAX_HITS_RESET = 11'd64;

   // Configuration register indexes.
   localparam logic REG_SYNC_WORD = 1'b0;
   localparam logic REG_MAX_HITS  = 1'b1;

   // Record kinds.
   localparam logic KIND_HIT = 1'b0;
   localparam logic KIND_END = 1'b1;

   // End record status.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] hit_offset;
      logic [6:0]  confidence;
      logic        sync_kind;
      logic [10:0] hit_count;
      logic        status;
      logic        last_of_run;
   } rsp_word_type;

   // Result words of one input word, packed to the front, with their count.
   typedef struct packed {
      logic [RCNT_W-1:0]                   count;
      rsp_word_type [RESULTS_MAX-1:0]      recs;
   } rsp_set_type;

   // Confidence of a hit found at a bit shift: 100 minus ten per bit.
   function automatic logic [6:0] shift_conf(input logic [2:0] shift);
      logic [6:0] conf;
      case (shift)
         3'd1:    conf = 7'd90;
         3'd2:    conf = 7'd80;
         3'd3:    conf = 7'd70;
         3'd4:    conf = 7'd60;
         3'd5:    conf = 7'd50;
         3'd6:    conf = 7'd40;
         3'd7:    conf = 7'd30;
         default: conf = FULL_CONF;
      endcase
      return conf;
   endfunction

endpackage

/* hw/rtl/swf_core.sv */
// swf_core: byte history, hit counting, configuration registers and match logic.
// Depends on swf_pkg.
module swf_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 take,
   input  swf_pkg::req_word_type word_in,
   output swf_pkg::rsp_set_type  set_out
);

   logic [15:0]                  sync_word_ff;
   logic [10:0]                  max_hits_ff;
   logic [7:0]                   older_ff, older_in;
   logic [7:0]                   newer_ff, newer_in;
   logic [swf_pkg::BSEEN_W-1:0]  seen_ff, seen_in;
   logic [10:0]                  hits_ff, hits_in;

   logic                         keep;
   logic [23:0]                  window;
   logic                         align1, shift_any, hit1;
   logic [2:0]                   shift_sel;
   logic [10:0]                  hits_a, hits_b;
   logic [7:0]                   older2, newer2;
   logic [swf_pkg::BSEEN_W-1:0]  seen2, off1, off2;
   logic                         hit2, short_buf;
   swf_pkg::rsp_word_type        rec1, rec2, rec_end;
   logic [1:0]                   pos;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= swf_pkg::SYNC_RESET;
         max_hits_ff  <= swf_pkg::MAX_HITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            swf_pkg::REG_SYNC_WORD: sync_word_ff <= csr_wdata;
            swf_pkg::REG_MAX_HITS:  max_hits_ff  <= csr_wdata[10:0];
            default:                ;
         endcase
      end
   end

   // Test at the offset two bytes back, using the new byte for shifts.
   always_comb begin
      keep      = seen_ff < swf_pkg::BSEEN_W'(swf_pkg::MAX_LEN);
      window    = {older_ff, newer_ff, word_in.data_byte};
      align1    = {older_ff, newer_ff} == sync_word_ff;
      shift_any = 1'b0;
      shift_sel = 3'd0;
      for (int s = 7; s >= 1; s--) begin
         if (window[(23 - s) -: 16] == sync_word_ff) begin
            shift_any = 1'b1;
            shift_sel = 3'(s);
         end
      end
      hit1 = keep && (seen_ff >= swf_pkg::BSEEN_W'(2)) && (hits_ff < max_hits_ff)
             && (align1 || shift_any);
      hits_a = hits_ff + 11'(hit1);
      off1   = seen_ff - swf_pkg::BSEEN_W'(2);

      rec1             = '0;
      rec1.kind        = swf_pkg::KIND_HIT;
      rec1.hit_offset  = off1[15:0];
      rec1.confidence  = align1 ? swf_pkg::FULL_CONF : swf_pkg::shift_conf(shift_sel);
      rec1.sync_kind   = align1 ? (sync_word_ff == swf_pkg::STD_SYNC) : 1'b1;
      rec1.hit_count   = hits_a;
      rec1.status      = swf_pkg::STATUS_OK;
      rec1.last_of_run = 1'b0;

      // Advance the history when the byte is kept.
      older2 = keep ? newer_ff : older_ff;
      newer2 = keep ? word_in.data_byte : newer_ff;
      seen2  = keep ? seen_ff + swf_pkg::BSEEN_W'(1) : seen_ff;

      // Final offset: aligned test only.
      short_buf = seen2 < swf_pkg::BSEEN_W'(2);
      off2      = seen2 - swf_pkg::BSEEN_W'(2);
      hit2      = word_in.end_of_buffer && !short_buf && (hits_a < max_hits_ff)
                  && ({older2, newer2} == sync_word_ff);
      hits_b    = hits_a + 11'(hit2);

      rec2             = '0;
      rec2.kind        = swf_pkg::KIND_HIT;
      rec2.hit_offset  = off2[15:0];
      rec2.confidence  = swf_pkg::FULL_CONF;
      rec2.sync_kind   = sync_word_ff == swf_pkg::STD_SYNC;
      rec2.hit_count   = hits_b;
      rec2.status      = swf_pkg::STATUS_OK;
      rec2.last_of_run = 1'b0;

      rec_end             = '0;
      rec_end.kind        = swf_pkg::KIND_END;
      rec_end.hit_count   = short_buf ? 11'd0 : hits_b;
      rec_end.status      = short_buf ? swf_pkg::STATUS_SHORT : swf_pkg::STATUS_OK;
      rec_end.last_of_run = 1'b1;

      // Pack the records to the front in order.
      set_out = '0;
      pos     = 2'd0;
      if (hit1) begin
         set_out.recs[pos] = rec1;
         pos = pos + 2'd1;
      end
      if (hit2) begin
         set_out.recs[pos] = rec2;
         pos = pos + 2'd1;
      end
      if (word_in.end_of_buffer) begin
         set_out.recs[pos] = rec_end;
         pos = pos + 2'd1;
      end
      set_out.count = swf_pkg::RCNT_W'(pos);

      // Drop all buffer state after the end record.
      if (word_in.end_of_buffer) begin
         older_in = '0;
         newer_in = '0;
         seen_in  = '0;
         hits_in  = '0;
      end else begin
         older_in = older2;
         newer_in = newer2;
         seen_in  = seen2;
         hits_in  = hits_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         seen_ff  <= '0;
         hits_ff  <= '0;
      end else if (take) begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         seen_ff  <= seen_in;
         hits_ff  <= hits_in;
      end
   end

endmodule

/* hw/rtl/swf_queue.sv */
// swf_queue: small result queue that takes up to three words at once and
// hands out one per cycle while rsp_ready holds. Depends on swf_pkg.
module swf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  swf_pkg::rsp_set_type  set_in,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swf_pkg::rsp_word_type rsp_data
);

   swf_pkg::rsp_word_type [swf_pkg::QUEUE_DEPTH-1:0] entry_ff;
   logic [swf_pkg::QPTR_W-1:0]  head_ff, head_in, tail;
   logic [swf_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        pop;
   logic [swf_pkg::RCNT_W-1:0]  n_push;

   assign room      = count_ff <= swf_pkg::QCNT_W'(swf_pkg::QUEUE_DEPTH - swf_pkg::RESULTS_MAX);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[head_ff];

   always_comb begin
      pop      = rsp_valid && rsp_ready;
      n_push   = push ? set_in.count : '0;
      tail     = head_ff + count_ff[swf_pkg::QPTR_W-1:0];
      head_in  = pop ? head_ff + swf_pkg::QPTR_W'(1) : head_ff;
      count_in = count_ff + swf_pkg::QCNT_W'(n_push) - swf_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < swf_pkg::RESULTS_MAX; i++) begin
         if (swf_pkg::RCNT_W'(i) < n_push) begin
            entry_ff[tail + swf_pkg::QPTR_W'(i)] <= set_in.recs[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/sync_word_finder.sv */
// sync_word_finder: top level of the sync word search over a raw track.
// Depends on swf_pkg, swf_core and swf_queue.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/ready    req_data  (swf_pkg::req_word_type)
//   rsp_     out        rsp_valid/ready    rsp_data  (swf_pkg::rsp_word_type)
//   csr_     in         csr_we             csr_index, csr_wdata (no read-back)
//
// One word per cycle in. Each word is matched in the cycle it is accepted
// and its zero to three result words land in a four-entry queue, which sends
// one word per cycle while rsp_ready holds; a word that causes one result
// keeps the rate at one per cycle. req_ready drops while the queue holds more
// than one word, so a stalled output backs up the input. Reset is synchronous
// and clears the byte history, counters and queue and restores the registers.
module sync_word_finder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swf_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swf_pkg::rsp_word_type rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   logic                 take;
   logic                 room;
   swf_pkg::rsp_set_type set;

   // Accept a word only while the queue can hold a full set of results.
   assign req_ready = room;
   assign take      = req_valid && room;

   // Match the word against the history and build its result words.
   swf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .word_in   (req_data),
      .set_out   (set)
   );

   // Hold results until the output side takes them.
   swf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .set_in    (set),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for sync_word_finder, with a driver, a monitor and
// a word-level prediction of the sync search. Depends on swf_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;

   // Confidence lost per bit of shift on a shifted hit.
   localparam int CONF_STEP   = 10;
   // Longest gap or stall either side draws.
   localparam int GAP_MAX     = 12;
   // Cycles without any word moving, with work pending, before giving up.
   localparam int STUCK_LIMIT = 2000;
   // Cycles to let the queue inside the block run dry before a register write.
   localparam int DRAIN_WAIT  = 8;
   // Cap on printed mismatch lines; every mismatch is still counted.
   localparam int PRINT_CAP   = 200;
   // Track bytes drawn by the random phases.
   localparam int RANDOM_BYTES = 240;

   typedef struct {
      swf_pkg::req_word_type word;
      int unsigned           gap;
   } track_slot_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   swf_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   swf_pkg::rsp_word_type rsp_data;
   logic                  csr_we = 1'b0;
   logic                  csr_index = swf_pkg::REG_SYNC_WORD;
   logic [15:0]           csr_wdata = '0;

   sync_word_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and expectations.
   track_slot_type        track_queue[$];
   swf_pkg::rsp_word_type due_records[$];
   int unsigned  bytes_queued = 0;
   int unsigned  bytes_accepted = 0;
   int unsigned  records_seen = 0;
   int unsigned  buffers_closed = 0;
   int unsigned  mismatches = 0;
   int unsigned  peak_hits = 0;
   int unsigned  random_bytes = 0;
   int unsigned  settings_used = 0;
   bit           calm = 1'b0;

   // Handshake flags: set at the rising edge, read at the falling edge.
   bit           req_fire = 1'b0;
   bit           rsp_fire = 1'b0;

   // Predicted copy of the registers and the search state.
   logic [15:0]  cfg_sync = swf_pkg::SYNC_RESET;
   logic [10:0]  cfg_max_hits = swf_pkg::MAX_HITS_RESET;
   logic [7:0]   older_byte = '0;
   logic [7:0]   newer_byte = '0;
   logic [16:0]  bytes_seen = '0;
   logic [10:0]  hits_found = '0;

   initial forever #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Test one offset: aligned first, then shifts 1..7 into the following byte
   // when there is one. The smallest matching shift wins.
   task automatic try_offset(input logic [16:0] offset, input logic [7:0] hi,
                             input logic [7:0] lo, input logic [7:0] nx,
                             input bit has_next);
      logic [23:0]           span;
      swf_pkg::rsp_word_type rec;
      bit                    found;
      int                    s;
      if (hits_found >= cfg_max_hits)
         return;
      found = 1'b0;
      rec = '0;
      rec.kind = swf_pkg::KIND_HIT;
      rec.hit_offset = offset[15:0];
      rec.status = swf_pkg::STATUS_OK;
      rec.last_of_run = 1'b0;
      if ({hi, lo} == cfg_sync) begin
         found = 1'b1;
         rec.confidence = swf_pkg::FULL_CONF;
         rec.sync_kind = (cfg_sync == swf_pkg::STD_SYNC);
      end else if (has_next) begin
         for (s = 1; s < 8 && !found; s++) begin
            span = {hi, lo, nx} << s;
            if (span[23:8] == cfg_sync) begin
               found = 1'b1;
               rec.confidence = 7'(swf_pkg::FULL_CONF - CONF_STEP * s);
               rec.sync_kind = 1'b1;
            end
         end
      end
      if (found) begin
         hits_found++;
         rec.hit_count = hits_found;
         due_records.push_back(rec);
         if (hits_found > peak_hits)
            peak_hits = hits_found;
      end
   endtask

   // Advance the search by one accepted word and queue what it should emit.
   task automatic scan_byte(input swf_pkg::req_word_type w);
      swf_pkg::rsp_word_type rec;
      logic                  st;
      if (bytes_seen < swf_pkg::MAX_LEN) begin
         if (bytes_seen >= 2)
            try_offset(bytes_seen - 17'd2, older_byte, newer_byte, w.data_byte, 1'b1);
         older_byte = newer_byte;
         newer_byte = w.data_byte;
         bytes_seen++;
      end
      if (w.end_of_buffer) begin
         // The final offset has no byte after it: aligned test only.
         st = swf_pkg::STATUS_OK;
         if (bytes_seen >= 2)
            try_offset(bytes_seen - 17'd2, older_byte, newer_byte, 8'h00, 1'b0);
         else
            st = swf_pkg::STATUS_SHORT;
         rec = '0;
         rec.kind = swf_pkg::KIND_END;
         rec.hit_count = (st == swf_pkg::STATUS_SHORT) ? 11'd0 : hits_found;
         rec.status = st;
         rec.last_of_run = 1'b1;
         due_records.push_back(rec);
         older_byte = '0;
         newer_byte = '0;
         bytes_seen = '0;
         hits_found = '0;
         buffers_closed++;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: present words at the falling edge, note acceptance at the rising one
   // ------------------------------------------------------------------
   int unsigned gap_count = 0;

   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) begin
         scan_byte(req_data);
         bytes_accepted++;
      end
   end

   always @(negedge clock) begin
      track_slot_type slot;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else if (!req_valid || req_fire) begin
         // Hold the next word back for its drawn gap, then present it.
         if (track_queue.size() != 0 && gap_count >= track_queue[0].gap) begin
            slot = track_queue.pop_front();
            req_data <= slot.word;
            req_valid <= 1'b1;
            gap_count = 0;
         end else begin
            req_valid <= 1'b0;
            if (track_queue.size() != 0)
               gap_count++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each accepted result word with the oldest expectation
   // ------------------------------------------------------------------
   int unsigned stall_count = 0;

   always @(posedge clock) begin
      swf_pkg::rsp_word_type want;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (rsp_fire) begin
         records_seen++;
         if (due_records.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
               $error("unexpected result word: kind %0d offset %0d count %0d",
                      rsp_data.kind, rsp_data.hit_offset, rsp_data.hit_count);
         end else begin
            want = due_records.pop_front();
            check_field("kind", want.kind, rsp_data.kind);
            check_field("hit_offset", want.hit_offset, rsp_data.hit_offset);
            check_field("confidence", want.confidence, rsp_data.confidence);
            check_field("sync_kind", want.sync_kind, rsp_data.sync_kind);
            check_field("hit_count", want.hit_count, rsp_data.hit_count);
            check_field("status", want.status, rsp_data.status);
            check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   // Draw a fresh stall after every result word taken; calm stretches draw none.
   always @(negedge clock) begin
      if (reset)
         stall_count = 0;
      else if (rsp_fire)
         stall_count = calm ? 0 : $urandom_range(0, GAP_MAX);
      else if (stall_count != 0)
         stall_count--;
      rsp_ready <= (stall_count == 0);
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles in which work is pending but no word moves
   // ------------------------------------------------------------------
   int unsigned stuck_cycles = 0;

   always @(negedge clock) begin
      if (!reset && (bytes_accepted != bytes_queued || due_records.size() != 0)
          && !req_fire && !rsp_fire)
         stuck_cycles++;
      else
         stuck_cycles = 0;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: %0d cycles without progress, %0d words queued, %0d results due",
                  stuck_cycles, bytes_queued - bytes_accepted, due_records.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b, input bit last);
      track_slot_type slot;
      slot.word.data_byte = b;
      slot.word.end_of_buffer = last;
      slot.gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      track_queue.push_back(slot);
      bytes_queued++;
   endtask

   // Wait until every word is in and every result is out, then let the block drain.
   task automatic settle();
      while (bytes_accepted != bytes_queued || due_records.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Pulse one register write; only called while the block is idle.
   task automatic write_reg(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == swf_pkg::REG_SYNC_WORD)
         cfg_sync = value;
      else
         cfg_max_hits = value[10:0];
      settings_used++;
   endtask

   // Three bytes whose bit stream carries the sync word shifted right by shift;
   // the bits around the pattern come from fill.
   task automatic plant_sync(input int shift, input logic [23:0] fill,
                             ref logic [7:0] bytes[$]);
      logic [23:0] mask;
      logic [23:0] span;
      mask = 24'hFFFF00 >> shift;
      span = (fill & ~mask) | ({cfg_sync, 8'h00} >> shift);
      bytes.push_back(span[23:16]);
      bytes.push_back(span[15:8]);
      bytes.push_back(span[7:0]);
   endtask

   // One random buffer of len bytes, mostly planted sync words among noise.
   // Leave it open when closed is clear so the next phase continues it.
   task automatic queue_buffer(input int len, input bit closed);
      logic [7:0] bytes[$];
      int         i;
      while (bytes.size() < len) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: plant_sync($urandom_range(0, 7), 24'($urandom()), bytes);
            4:          bytes.push_back(8'h00);
            5:          bytes.push_back(8'hFF);
            default:    bytes.push_back(8'($urandom()));
         endcase
      end
      for (i = 0; i < len; i++)
         push_byte(bytes[i], closed && i == len - 1);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [7:0]  bytes[$];
      logic [15:0] sync_pick;
      logic [10:0] limit_pick;
      int          nbuf;
      int          len;
      int          b;
      int          i;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset registers: a one-byte buffer ends short.
      push_byte(8'hA5, 1'b1);
      // Standard sync at the final offset: aligned test only, still a hit.
      push_byte(8'h44, 1'b0);
      push_byte(8'h89, 1'b1);
      // Shifted hits at one and seven bits, then a shifted pattern that starts
      // at the final offset and so must not be found.
      plant_sync(1, 24'h000000, bytes);
      plant_sync(7, 24'hFFFFFF, bytes);
      plant_sync(3, 24'h000000, bytes);
      for (i = 0; i < 8; i++)
         push_byte(bytes[i], i == 7);
      bytes.delete();
      // Byte extremes with no match.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      settle();

      // Non-standard sync, limit of one: one hit, the rest suppressed.
      write_reg(swf_pkg::REG_SYNC_WORD, 16'hFFFF);
      write_reg(swf_pkg::REG_MAX_HITS, 11'd1);
      for (i = 0; i < 4; i++)
         push_byte(8'hFF, i == 3);
      settle();

      // Limit of zero records nothing even on a perfect match.
      write_reg(swf_pkg::REG_SYNC_WORD, 16'h0000);
      write_reg(swf_pkg::REG_MAX_HITS, 11'd0);
      for (i = 0; i < 3; i++)
         push_byte(8'h00, i == 2);

      // Random phases: new settings while idle, some buffers left open across
      // a change, calm stretches mixed with heavy idling on both sides.
      while (random_bytes < RANDOM_BYTES) begin
         settle();
         case ($urandom_range(0, 5))
            0:       sync_pick = 16'h0000;
            1:       sync_pick = 16'hFFFF;
            2:       sync_pick = swf_pkg::STD_SYNC;
            default: sync_pick = 16'($urandom());
         endcase
         write_reg(swf_pkg::REG_SYNC_WORD, sync_pick);
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 6))
               0:       limit_pick = 11'd0;
               1:       limit_pick = 11'd1;
               2:       limit_pick = 11'd2;
               3:       limit_pick = 11'd1024;
               4:       limit_pick = 11'd2047;
               default: limit_pick = 11'($urandom_range(3, 20));
            endcase
            write_reg(swf_pkg::REG_MAX_HITS, limit_pick);
         end
         calm = ($urandom_range(0, 3) == 0);
         nbuf = $urandom_range(1, 4);
         for (b = 0; b < nbuf; b++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                              : $urandom_range(3, 24);
            queue_buffer(len, !(b == nbuf - 1 && $urandom_range(0, 4) == 0));
            random_bytes += len;
         end
      end
      // Close whatever buffer is still open.
      push_byte(8'($urandom()), 1'b1);
      settle();
      repeat (20) @(negedge clock);

      $display("Run covered %0d track bytes in %0d buffers, %0d result words checked.",
               bytes_accepted, buffers_closed, records_seen);
      $display("Register writes: %0d; highest hit count reached: %0d; mismatches: %0d.",
               settings_used, peak_hits, mismatches);
      if (mismatches == 0 && due_records.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/swf_pkg.sv
hw/rtl/swf_core.sv
hw/rtl/swf_queue.sv
hw/rtl/sync_word_finder.sv
sim/tb_top.sv
